>>> rtl/mett_pkg.sv
// Shared types, widths, codes and reset values for the motor encoder turn tracker.
`default_nettype none

package mett_pkg;

    // Field widths
    localparam int ANGLE_W   = 13;   // rotor encoder angle, 8192 counts per turn
    localparam int SPEED_W   = 16;
    localparam int CURR_W    = 16;
    localparam int COUNT_W   = 32;
    localparam int TURNS_W   = 32;
    localparam int SHAFT_W   = 16;   // shaft angle, 65536 units per turn
    localparam int EVENT_W   = 2;
    localparam int KIND_W    = 2;
    localparam int RATIO_W   = 8;
    localparam int ROTOR_W   = 10;   // signed rotor turn count
    localparam int QUOT_W    = ROTOR_W + 1;

    // angle * 65536 / (ratio * 8192) == (angle << FRAC_SHIFT) / ratio
    localparam int FRAC_SHIFT = SHAFT_W - ANGLE_W;

    // Stream word widths, padded to whole bytes
    localparam int IN_BITS   = ANGLE_W + SPEED_W + CURR_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS  = COUNT_W + SPEED_W + CURR_W + TURNS_W + SHAFT_W + EVENT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_KIND    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_HI = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_LO = 2'd3;

    // Motor kinds
    localparam logic [KIND_W-1:0] KIND_GEARED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DIRECT = 2'd1;

    // Wrap event codes
    localparam logic [EVENT_W-1:0] WRAP_NONE = 2'd0;
    localparam logic [EVENT_W-1:0] WRAP_BACK = 2'd1;
    localparam logic [EVENT_W-1:0] WRAP_FWD  = 2'd2;
    localparam logic [EVENT_W-1:0] WRAP_BAD  = 2'd3;

    // Register reset values
    localparam logic [KIND_W-1:0]  RST_KIND    = KIND_GEARED;
    localparam logic [RATIO_W-1:0] RST_RATIO   = 8'd19;
    localparam logic [ANGLE_W-1:0] RST_WRAP_HI = 13'd6700;
    localparam logic [ANGLE_W-1:0] RST_WRAP_LO = 13'd1500;

    // Rotor turn saturation limits
    localparam logic signed [QUOT_W-1:0] ROTOR_MAX = 11'sd511;
    localparam logic signed [QUOT_W-1:0] ROTOR_MIN = -11'sd512;

    // Divider step counts
    localparam int CNT_W = 5;
    localparam logic [CNT_W-1:0] ROT_STEPS = 5'd10;
    localparam logic [CNT_W-1:0] ANG_STEPS = 5'd16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_ROT,
        ST_ROT_FIX,
        ST_DIV_ANG,
        ST_FINISH
    } t_state;

endpackage

`default_nettype wire

>>> rtl/motor_encoder_turn_tracker.sv
// Top level of the motor encoder turn tracker: frame intake, wrap detection, serial divider.
`default_nettype none

// Multi-turn position tracker for motor feedback frames. Each input word carries a
// 13-bit rotor angle, speed and current; each output word carries the frame count,
// the passed-through speed and current, the saturating output-shaft turn count, the
// 16-bit shaft angle and the wrap event code. Frames of an unsupported motor kind are
// taken and dropped with no output word. A wrap frame skips the divider; a direct-drive
// frame runs only the angle division, a geared frame the rotor-turn division, a fixup
// and the angle division. The input is ready again in the cycle after the result moves
// into the output register. One shared restoring divider resolves one quotient bit per
// cycle: 10 steps for the rotor-turn carry (floor division by the reduction ratio) and
// 16 steps for the shaft angle fraction. The output register holds a finished word
// while the downstream side stalls. Configuration writes belong to idle periods only.
module motor_encoder_turn_tracker (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // config
    input  wire                                 i_cfg_we,
    input  wire [mett_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire [mett_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input stream
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    // raw_angle[12:0], raw_speed[28:13], raw_current[44:29], zero pad [47:45]
    input  wire [mett_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // output stream
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // frame_count[31:0], speed[47:32], current[63:48], shaft_turns[95:64],
    // shaft_angle[111:96], wrap_event[113:112], zero pad [119:114]
    output logic [mett_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    // ---------------------------------------------------------------- registers
    mett_pkg::t_state r_state, n_state;

    logic [mett_pkg::KIND_W-1:0]   r_kind;
    logic [mett_pkg::RATIO_W-1:0]  r_ratio;
    logic [mett_pkg::ANGLE_W-1:0]  r_wrap_hi;
    logic [mett_pkg::ANGLE_W-1:0]  r_wrap_lo;

    logic                          r_seen;
    logic [mett_pkg::ANGLE_W-1:0]  r_prev;
    logic [mett_pkg::COUNT_W-1:0]  r_frames;
    logic signed [mett_pkg::ROTOR_W-1:0] r_rotor;
    logic signed [mett_pkg::TURNS_W-1:0] r_whole;
    logic [mett_pkg::SHAFT_W-1:0]  r_last;

    // frame payload held while the divider runs
    logic [mett_pkg::ANGLE_W-1:0]  r_angle;
    logic [mett_pkg::SPEED_W-1:0]  r_speed;
    logic [mett_pkg::CURR_W-1:0]   r_current;
    logic [mett_pkg::EVENT_W-1:0]  r_event;
    logic                          r_neg;

    // shared restoring divider
    logic [mett_pkg::CNT_W-1:0]    r_cnt;
    logic [mett_pkg::RATIO_W-1:0]  r_rem;
    logic [mett_pkg::SHAFT_W-1:0]  r_dvd;
    logic [mett_pkg::SHAFT_W-1:0]  r_quo;

    // output register
    logic                          r_out_valid;
    logic [mett_pkg::OUT_DATA_W-1:0] r_out_data;

    // ---------------------------------------------------------------- input decode
    logic [mett_pkg::ANGLE_W-1:0]  w_in_angle;
    logic [mett_pkg::ANGLE_W-1:0]  w_in_prev;
    logic [mett_pkg::EVENT_W-1:0]  w_in_event;
    logic                          w_accept;
    logic                          w_take;
    logic                          w_out_load;
    logic [mett_pkg::RATIO_W-1:0]  w_ratio;

    assign w_in_angle = s_axis_tdata[mett_pkg::ANGLE_W-1:0];
    assign w_accept   = s_axis_tvalid && s_axis_tready;
    // unsupported kinds are swallowed without touching state
    assign w_take     = w_accept && (r_kind == mett_pkg::KIND_GEARED ||
                                     r_kind == mett_pkg::KIND_DIRECT);
    assign w_ratio    = (r_ratio == '0) ? mett_pkg::RATIO_W'(1) : r_ratio;

    // first frame compares against itself, so it can wrap only when the low threshold lies above the high one
    assign w_in_prev  = r_seen ? r_prev : w_in_angle;

    always_comb begin
        if (w_in_angle > r_wrap_hi && w_in_prev < r_wrap_lo) begin
            w_in_event = mett_pkg::WRAP_BACK;
        end else if (w_in_angle < r_wrap_lo && w_in_prev > r_wrap_hi) begin
            w_in_event = mett_pkg::WRAP_FWD;
        end else begin
            w_in_event = mett_pkg::WRAP_NONE;
        end
    end

    // ---------------------------------------------------------------- divider step
    // One quotient bit per cycle; the partial remainder always stays below the ratio.
    logic [mett_pkg::RATIO_W:0]    w_trial;
    logic                          w_ge;
    logic [mett_pkg::RATIO_W:0]    w_diff;
    logic [mett_pkg::RATIO_W-1:0]  n_rem;

    assign w_trial = {r_rem, r_dvd[mett_pkg::SHAFT_W-1]};
    assign w_ge    = (w_trial >= {1'b0, w_ratio});
    assign w_diff  = w_trial - {1'b0, w_ratio};
    assign n_rem   = w_ge ? w_diff[mett_pkg::RATIO_W-1:0] : w_trial[mett_pkg::RATIO_W-1:0];

    // ---------------------------------------------------------------- rotor carry fixup
    // Floor division of a negative count: negate the magnitude quotient and round down.
    logic [mett_pkg::ROTOR_W-1:0]  w_rotor_mag;
    logic                          w_rem_nz;
    logic [mett_pkg::QUOT_W-1:0]   w_qmag;
    logic signed [mett_pkg::QUOT_W-1:0] w_carry;
    logic [mett_pkg::RATIO_W-1:0]  w_rotor_rem;

    assign w_rotor_mag = r_rotor[mett_pkg::ROTOR_W-1] ?
                         (~r_rotor + mett_pkg::ROTOR_W'(1)) : r_rotor;
    assign w_rem_nz    = (r_rem != '0);
    assign w_qmag      = {1'b0, r_quo[mett_pkg::ROTOR_W-1:0]}
                         + mett_pkg::QUOT_W'(r_neg && w_rem_nz);
    assign w_carry     = r_neg ? -$signed(w_qmag) : $signed(w_qmag);
    assign w_rotor_rem = (r_neg && w_rem_nz) ? (w_ratio - r_rem) : r_rem;

    // ---------------------------------------------------------------- saturating adders
    logic signed [mett_pkg::QUOT_W-1:0]  w_whole_add;
    logic signed [mett_pkg::TURNS_W:0]   w_whole_sum;
    logic signed [mett_pkg::TURNS_W-1:0] w_whole_sat;
    logic signed [mett_pkg::QUOT_W-1:0]  w_step;
    logic signed [mett_pkg::QUOT_W-1:0]  w_rotor_sum;
    logic signed [mett_pkg::ROTOR_W-1:0] w_rotor_sat;

    assign w_step = (w_in_event == mett_pkg::WRAP_BACK) ? -mett_pkg::QUOT_W'(1)
                                                        : mett_pkg::QUOT_W'(1);

    // whole turns take a wrap step on direct motors, or the rotor carry on geared ones
    assign w_whole_add = (r_state == mett_pkg::ST_ROT_FIX) ? w_carry : w_step;
    assign w_whole_sum = {r_whole[mett_pkg::TURNS_W-1], r_whole}
                         + (mett_pkg::TURNS_W+1)'(w_whole_add);

    always_comb begin
        if (w_whole_sum[mett_pkg::TURNS_W] != w_whole_sum[mett_pkg::TURNS_W-1]) begin
            // clamp toward the sign of the true sum
            w_whole_sat = w_whole_sum[mett_pkg::TURNS_W] ?
                          {1'b1, {(mett_pkg::TURNS_W-1){1'b0}}} :
                          {1'b0, {(mett_pkg::TURNS_W-1){1'b1}}};
        end else begin
            w_whole_sat = w_whole_sum[mett_pkg::TURNS_W-1:0];
        end
    end

    assign w_rotor_sum = mett_pkg::QUOT_W'(r_rotor) + w_step;

    always_comb begin
        if (w_rotor_sum > mett_pkg::ROTOR_MAX) begin
            w_rotor_sat = mett_pkg::ROTOR_W'(mett_pkg::ROTOR_MAX);
        end else if (w_rotor_sum < mett_pkg::ROTOR_MIN) begin
            w_rotor_sat = mett_pkg::ROTOR_W'(mett_pkg::ROTOR_MIN);
        end else begin
            w_rotor_sat = w_rotor_sum[mett_pkg::ROTOR_W-1:0];
        end
    end

    // ---------------------------------------------------------------- FSM outputs
    always_comb begin
        s_axis_tready = (r_state == mett_pkg::ST_IDLE);
        w_out_load    = (r_state == mett_pkg::ST_FINISH) &&
                        (!r_out_valid || m_axis_tready);
    end

    // ---------------------------------------------------------------- FSM next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mett_pkg::ST_IDLE: begin
                if (w_take) begin
                    if (w_in_event != mett_pkg::WRAP_NONE) begin
                        n_state = mett_pkg::ST_FINISH;
                    end else if (r_kind == mett_pkg::KIND_GEARED) begin
                        n_state = mett_pkg::ST_DIV_ROT;
                    end else begin
                        n_state = mett_pkg::ST_DIV_ANG;
                    end
                end
            end
            mett_pkg::ST_DIV_ROT: begin
                if (r_cnt == mett_pkg::CNT_W'(1)) begin
                    n_state = mett_pkg::ST_ROT_FIX;
                end
            end
            mett_pkg::ST_ROT_FIX: begin
                n_state = mett_pkg::ST_DIV_ANG;
            end
            mett_pkg::ST_DIV_ANG: begin
                if (r_cnt == mett_pkg::CNT_W'(1)) begin
                    n_state = mett_pkg::ST_FINISH;
                end
            end
            mett_pkg::ST_FINISH: begin
                if (w_out_load) begin
                    n_state = mett_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mett_pkg::ST_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mett_pkg::ST_IDLE;
            r_kind      <= mett_pkg::RST_KIND;
            r_ratio     <= mett_pkg::RST_RATIO;
            r_wrap_hi   <= mett_pkg::RST_WRAP_HI;
            r_wrap_lo   <= mett_pkg::RST_WRAP_LO;
            r_seen      <= 1'b0;
            r_prev      <= '0;
            r_frames    <= '0;
            r_rotor     <= '0;
            r_whole     <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    mett_pkg::REG_KIND:    r_kind    <= i_cfg_data[mett_pkg::KIND_W-1:0];
                    mett_pkg::REG_RATIO:   r_ratio   <= i_cfg_data[mett_pkg::RATIO_W-1:0];
                    mett_pkg::REG_WRAP_HI: r_wrap_hi <= i_cfg_data[mett_pkg::ANGLE_W-1:0];
                    mett_pkg::REG_WRAP_LO: r_wrap_lo <= i_cfg_data[mett_pkg::ANGLE_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (w_take) begin
                r_frames <= r_frames + mett_pkg::COUNT_W'(1);
                r_seen   <= 1'b1;
                r_prev   <= w_in_angle;
                if (w_in_event != mett_pkg::WRAP_NONE) begin
                    if (r_kind == mett_pkg::KIND_GEARED) begin
                        r_rotor <= w_rotor_sat;
                    end else begin
                        r_whole <= w_whole_sat;
                    end
                end
            end

            // carry whole rotor turns into shaft turns
            if (r_state == mett_pkg::ST_ROT_FIX) begin
                r_rotor <= mett_pkg::ROTOR_W'(w_rotor_rem);
                r_whole <= w_whole_sat;
            end

            // remember the angle of the last non-wrap frame
            if (r_state == mett_pkg::ST_DIV_ANG && r_cnt == mett_pkg::CNT_W'(1)) begin
                r_last <= {r_quo[mett_pkg::SHAFT_W-2:0], w_ge};
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            mett_pkg::ST_IDLE: begin
                if (w_take) begin
                    r_angle   <= w_in_angle;
                    r_speed   <= s_axis_tdata[mett_pkg::ANGLE_W +: mett_pkg::SPEED_W];
                    r_current <= s_axis_tdata[mett_pkg::ANGLE_W+mett_pkg::SPEED_W +:
                                              mett_pkg::CURR_W];
                    r_event   <= w_in_event;
                    r_neg     <= r_rotor[mett_pkg::ROTOR_W-1];
                    r_quo     <= r_last;   // wrap frames repeat the last angle
                    if (r_kind == mett_pkg::KIND_GEARED) begin
                        // divide the rotor count magnitude by the ratio
                        r_rem <= '0;
                        r_dvd <= {w_rotor_mag, {(mett_pkg::SHAFT_W-mett_pkg::ROTOR_W){1'b0}}};
                        r_cnt <= mett_pkg::ROT_STEPS;
                    end else begin
                        r_rem <= '0;
                        r_dvd <= {w_in_angle, {mett_pkg::FRAC_SHIFT{1'b0}}};
                        r_cnt <= mett_pkg::ANG_STEPS;
                    end
                end
            end
            mett_pkg::ST_DIV_ROT, mett_pkg::ST_DIV_ANG: begin
                r_rem <= n_rem;
                r_dvd <= {r_dvd[mett_pkg::SHAFT_W-2:0], 1'b0};
                r_quo <= {r_quo[mett_pkg::SHAFT_W-2:0], w_ge};
                r_cnt <= r_cnt - mett_pkg::CNT_W'(1);
            end
            mett_pkg::ST_ROT_FIX: begin
                // rotor remainder forms the top of the shaft-angle dividend
                r_rem <= w_rotor_rem;
                r_dvd <= {r_angle, {mett_pkg::FRAC_SHIFT{1'b0}}};
                r_quo <= '0;
                r_cnt <= mett_pkg::ANG_STEPS;
            end
            mett_pkg::ST_FINISH: begin
                if (w_out_load) begin
                    r_out_data <= {{(mett_pkg::OUT_DATA_W-mett_pkg::OUT_BITS){1'b0}},
                                   r_event, r_quo, r_whole, r_current, r_speed, r_frames};
                end
            end
            default: begin
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

`default_nettype wire

>>> rtl/mett_checker.sv
// Port-level checker for the motor encoder turn tracker, bound to the top level.
`default_nettype none

module mett_checker (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              s_axis_tready,
    input wire                              m_axis_tvalid,
    input wire                              m_axis_tready,
    input wire [mett_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed while stalled");

    // wrap code three never leaves the block
    a_event_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[113:112] != mett_pkg::WRAP_BAD)
        else $error("illegal wrap event code");

    // reset empties the output and opens the input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("reset did not clear the handshake state");

endmodule

bind motor_encoder_turn_tracker mett_checker u_mett_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

>>> bench/motor_encoder_turn_tracker_tb.sv
// Testbench for the motor encoder turn tracker: directed and random frames checked by a predictor.
module motor_encoder_turn_tracker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mett_pkg::*;

    // Kinds the package leaves unnamed: both must drop the frame without a word out
    localparam logic [KIND_W-1:0] KIND_UNSUPPORTED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESERVED    = 2'd3;

    localparam longint COUNTS_PER_TURN = longint'(1) << ANGLE_W;
    localparam int     DRAIN_CYCLES    = 40;    // outlasts a geared frame, with margin
    localparam int     HOLD_CYCLES     = 400;   // long downstream stall, fills the block
    localparam int     HOLD_AFTER      = 40;    // words seen before the long stall starts

    // Input word, angle in the low bits
    typedef struct packed {
        logic signed [CURR_W-1:0]  current;
        logic signed [SPEED_W-1:0] speed;
        logic [ANGLE_W-1:0]        angle;
    } feedback_frame_t;

    // Output word, frame count in the low bits
    typedef struct packed {
        logic [EVENT_W-1:0]        wrap_code;
        logic [SHAFT_W-1:0]        shaft_angle;
        logic signed [TURNS_W-1:0] shaft_turns;
        logic signed [CURR_W-1:0]  current;
        logic signed [SPEED_W-1:0] speed;
        logic [COUNT_W-1:0]        frame_count;
    } shaft_position_t;

    // Tracks rotor and shaft turns the way the block should, and holds the words it owes
    class shaft_position_predictor;
        logic [KIND_W-1:0]  kind;
        logic [RATIO_W-1:0] ratio;
        logic [ANGLE_W-1:0] wrap_hi;
        logic [ANGLE_W-1:0] wrap_lo;
        bit                 seen_first;
        logic [ANGLE_W-1:0] prev_angle;
        logic [COUNT_W-1:0] frames_seen;
        int                 rotor_turns;
        longint             whole_turns;
        logic [SHAFT_W-1:0] last_shaft_angle;
        shaft_position_t    expected_positions[$];
        logic [COUNT_W-1:0] current_frame;
        int                 errors;

        function void clear();
            kind             = RST_KIND;
            ratio            = RST_RATIO;
            wrap_hi          = RST_WRAP_HI;
            wrap_lo          = RST_WRAP_LO;
            seen_first       = 1'b0;
            prev_angle       = '0;
            frames_seen      = '0;
            rotor_turns      = 0;
            whole_turns      = 0;
            last_shaft_angle = '0;
            current_frame    = '0;
            errors           = 0;
            expected_positions.delete();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_KIND:    kind    = value[KIND_W-1:0];
                REG_RATIO:   ratio   = value[RATIO_W-1:0];
                REG_WRAP_HI: wrap_hi = value[ANGLE_W-1:0];
                REG_WRAP_LO: wrap_lo = value[ANGLE_W-1:0];
                default: ;
            endcase
        endfunction

        function longint clamp_turns(longint value);
            if (value > 64'sd2147483647) return 64'sd2147483647;
            if (value < -64'sd2147483648) return -64'sd2147483648;
            return value;
        endfunction

        function void note_frame(feedback_frame_t f);
            logic [ANGLE_W-1:0] prev;
            logic [EVENT_W-1:0] wrap;
            longint             divisor;
            longint             quot;
            longint             num;
            longint             shaft;
            shaft_position_t    want;
            // Unsupported kinds leave all state alone
            if (kind != KIND_GEARED && kind != KIND_DIRECT) return;
            frames_seen = frames_seen + 1'b1;
            prev        = seen_first ? prev_angle : f.angle;
            seen_first  = 1'b1;
            prev_angle  = f.angle;
            divisor     = (ratio == '0) ? 64'sd1 : longint'(ratio);

            if (f.angle > wrap_hi && prev < wrap_lo)
                wrap = WRAP_BACK;
            else if (f.angle < wrap_lo && prev > wrap_hi)
                wrap = WRAP_FWD;
            else
                wrap = WRAP_NONE;

            if (wrap != WRAP_NONE) begin
                // Wrap frames only step a count and repeat the last angle
                if (kind == KIND_GEARED) begin
                    rotor_turns += (wrap == WRAP_BACK) ? -1 : 1;
                    if (rotor_turns > 511) rotor_turns = 511;
                    if (rotor_turns < -512) rotor_turns = -512;
                end else begin
                    whole_turns = clamp_turns(whole_turns + ((wrap == WRAP_BACK) ? -1 : 1));
                end
                shaft = last_shaft_angle;
            end else begin
                if (kind == KIND_GEARED) begin
                    // Floor division carries whole shaft turns out of the rotor count
                    if (rotor_turns >= 0)
                        quot = rotor_turns / divisor;
                    else
                        quot = -((-longint'(rotor_turns) + divisor - 1) / divisor);
                    rotor_turns = rotor_turns - int'(quot * divisor);
                    whole_turns = clamp_turns(whole_turns + quot);
                    num = longint'(rotor_turns) * COUNTS_PER_TURN + longint'(f.angle);
                end else begin
                    num = longint'(f.angle);
                end
                shaft = ((num << 16) / (divisor * COUNTS_PER_TURN)) % 65536;
                last_shaft_angle = shaft[SHAFT_W-1:0];
            end

            want.frame_count = frames_seen;
            want.speed       = f.speed;
            want.current     = f.current;
            want.shaft_turns = whole_turns[TURNS_W-1:0];
            want.shaft_angle = shaft[SHAFT_W-1:0];
            want.wrap_code   = wrap;
            expected_positions.push_back(want);
        endfunction

        task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
            $display("%0t ns: MISMATCH frame %0d %s: got 'h%0h, want 'h%0h",
                     $time, current_frame, what, got, want);
            errors++;
        endtask

        task check_position(logic [OUT_DATA_W-1:0] word);
            shaft_position_t got;
            shaft_position_t want;
            got = word[OUT_BITS-1:0];
            if (expected_positions.size() == 0) begin
                current_frame = got.frame_count;
                report_mismatch("word with nothing expected", word[63:0], '0);
                return;
            end
            want          = expected_positions.pop_front();
            current_frame = want.frame_count;
            if (got.frame_count !== want.frame_count)
                report_mismatch("frame_count", got.frame_count, want.frame_count);
            if (got.speed !== want.speed)
                report_mismatch("speed", got.speed, want.speed);
            if (got.current !== want.current)
                report_mismatch("current", got.current, want.current);
            if (got.shaft_turns !== want.shaft_turns)
                report_mismatch("shaft_turns", got.shaft_turns, want.shaft_turns);
            if (got.shaft_angle !== want.shaft_angle)
                report_mismatch("shaft_angle", got.shaft_angle, want.shaft_angle);
            if (got.wrap_code !== want.wrap_code)
                report_mismatch("wrap_event", got.wrap_code, want.wrap_code);
            if (word[OUT_DATA_W-1:OUT_BITS] !== '0)
                report_mismatch("pad bits", word[OUT_DATA_W-1:OUT_BITS], '0);
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // raw_angle, raw_speed, raw_current, zero pad (from the lowest bit up)
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // frame_count, speed, current, shaft_turns, shaft_angle, wrap_event, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    shaft_position_predictor positions;
    int                      results_seen;
    int                      burst_left;
    int                      encoder_pos;

    // Directed opening: first frame near the top, a forward and a backward wrap, exact
    // threshold values that must not wrap, a negative rotor count carried into the shaft
    int          directed_angles [13] = '{8000, 100, 0, 8191, 4000, 1499, 6701,
                                          5000, 6700, 1500, 6701, 1499, 3000};
    logic [15:0] directed_values [6]  = '{16'h7FFF, 16'h8000, 16'h0000,
                                          16'hFFFF, 16'h5555, 16'hAAAA};

    motor_encoder_turn_tracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake never completes
    initial begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Check every word the block hands over; values are read before the edge updates them
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            positions.check_position(m_axis_tdata);
        end
    end

    // Downstream side: the stall pattern changes after random stretches, from never stalling
    // to stalling most of the time. Once, early on, hold off for a long stretch so the
    // output register fills and the block has to stall its input.
    initial begin : downstream
        int  mode_left;
        int  stall_pct;
        bit  held;
        mode_left     = 0;
        stall_pct     = 0;
        held          = 1'b0;
        m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= HOLD_AFTER) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                held = 1'b1;
            end
            if (mode_left == 0) begin
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                mode_left = $urandom_range(10, 120);
            end
            mode_left--;
            m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic feedback_frame_t make_frame(int angle);
        feedback_frame_t f;
        f.angle   = angle[ANGLE_W-1:0];
        f.speed   = SPEED_W'($urandom_range(0, 65535));
        f.current = CURR_W'($urandom_range(0, 65535));
        return f;
    endfunction

    // Offer one word and hold it until taken. Called at a falling edge; returns at one.
    // Valid stays high into the next word of a burst; at the end of a burst, drop valid
    // for a random gap (or go straight on, so some bursts run back to back).
    task automatic send_frame(feedback_frame_t f);
        s_axis_tdata  = {{(IN_DATA_W - IN_BITS){1'b0}}, f};
        s_axis_tvalid = 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        positions.note_frame(f);
        @(negedge i_clk);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0) begin
                s_axis_tvalid = 1'b0;
                s_axis_tdata  = IN_DATA_W'({$urandom, $urandom});
                repeat ($urandom_range(1, 25)) @(negedge i_clk);
            end
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        positions.write_reg(idx, value);
    endtask

    // Drain: wait for every owed word, then give dropped frames time to clear the block
    task automatic wait_for_idle();
        s_axis_tvalid = 1'b0;
        while (positions.expected_positions.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Turn the rotor in one direction with occasional reversals and random jumps;
    // big steps carry it across the top of the turn so wraps come often
    task automatic run_rotation(int count, int max_step);
        int dir;
        int step;
        dir = ($urandom_range(0, 1) == 1) ? 1 : -1;
        repeat (count) begin
            if ($urandom_range(0, 9) == 0) dir = -dir;
            if ($urandom_range(0, 6) == 0) begin
                encoder_pos = $urandom_range(0, 8191);
            end else begin
                step        = $urandom_range(0, max_step);
                encoder_pos = (encoder_pos + dir * step + 8192) % 8192;
            end
            send_frame(make_frame(encoder_pos));
        end
    endtask

    // Angles strictly between the thresholds: with low above high, each one wraps backward
    task automatic run_backward_chain(int count, int lo_angle, int hi_angle);
        repeat (count) send_frame(make_frame($urandom_range(lo_angle, hi_angle)));
    endtask

    initial begin : stimulus
        feedback_frame_t f;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        results_seen  = 0;
        burst_left    = 1;
        encoder_pos   = 0;
        positions     = new();
        positions.clear();

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Reset settings: geared, ratio 19, thresholds 6700 and 1500
        for (int i = 0; i < 13; i++) begin
            f.angle   = directed_angles[i][ANGLE_W-1:0];
            f.speed   = directed_values[i % 6];
            f.current = directed_values[(i + 1) % 6];
            send_frame(f);
        end
        run_rotation(60, 2500);
        wait_for_idle();

        // Direct drive, ratio 1, thresholds wide open: nearly every frame wraps
        write_reg(REG_KIND, KIND_DIRECT);
        write_reg(REG_RATIO, 13'd1);
        write_reg(REG_WRAP_HI, 13'd0);
        write_reg(REG_WRAP_LO, 13'd8191);
        run_rotation(40, 2500);
        wait_for_idle();

        // Direct drive, largest ratio, thresholds shut: never wraps
        write_reg(REG_RATIO, 13'd255);
        write_reg(REG_WRAP_HI, 13'd8191);
        write_reg(REG_WRAP_LO, 13'd0);
        run_rotation(40, 2500);
        wait_for_idle();

        // Direct drive, normal thresholds, some middle ratio
        write_reg(REG_RATIO, CFG_DATA_W'($urandom_range(2, 254)));
        write_reg(REG_WRAP_HI, 13'd6700);
        write_reg(REG_WRAP_LO, 13'd1500);
        run_rotation(40, 2500);
        wait_for_idle();

        // Unsupported kinds: frames are taken and dropped; junk in the upper data bits
        write_reg(REG_KIND, KIND_UNSUPPORTED);
        run_rotation(15, 2500);
        wait_for_idle();
        write_reg(REG_KIND, CFG_DATA_W'({$urandom_range(0, 2047), KIND_RESERVED}));
        run_rotation(15, 2500);
        wait_for_idle();

        // Geared, zero ratio acts as one
        write_reg(REG_KIND, CFG_DATA_W'({$urandom_range(0, 2047), KIND_GEARED}));
        write_reg(REG_RATIO, CFG_DATA_W'({$urandom_range(0, 31), 8'd0}));
        run_rotation(30, 2500);
        wait_for_idle();

        // Geared, ratio 1, low threshold above high: a long run of backward wraps
        // drives the rotor count into its lower limit
        write_reg(REG_RATIO, 13'd1);
        write_reg(REG_WRAP_HI, 13'd100);
        write_reg(REG_WRAP_LO, 13'd8000);
        run_backward_chain(540, 101, 7999);
        wait_for_idle();

        // Geared, largest ratio, normal thresholds; the first plain frame carries the
        // saturated rotor count into shaft turns
        write_reg(REG_RATIO, 13'd255);
        write_reg(REG_WRAP_HI, 13'd6700);
        write_reg(REG_WRAP_LO, 13'd1500);
        run_rotation(50, 2500);
        wait_for_idle();

        // Random settings, kind and thresholds included
        repeat (3) begin
            write_reg(REG_KIND, CFG_DATA_W'($urandom_range(0, 3)));
            write_reg(REG_RATIO, CFG_DATA_W'($urandom_range(0, 255)));
            write_reg(REG_WRAP_HI, CFG_DATA_W'($urandom_range(4096, 8191)));
            write_reg(REG_WRAP_LO, CFG_DATA_W'($urandom_range(0, 4095)));
            run_rotation(30, 3000);
            wait_for_idle();
        end

        if (positions.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
